FILE: rtl/pno_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pno_pkg: shared types and constants for the polyline normal offset block
// Payload structs, controller commands and datapath status.
// ----------------------------------------------------------------------------
package pno_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned UnitW  = 32;   // signed Q1.30 unit component

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic                     point_last;
    } t_in_item;

    typedef struct packed {
        logic signed [CoordW-1:0] out_x;
        logic signed [CoordW-1:0] out_y;
        logic                     out_last;
    } t_out_item;

    // normalize source select
    typedef enum logic [1:0] {
        SRC_EDGE_NEW = 2'd0,   // segment from held point to incoming point
        SRC_EDGE_OLD = 2'd1,   // segment from older point to held point
        SRC_SUM      = 2'd2    // sum of the two left normals
    } t_norm_src;

    // controller to datapath commands
    typedef struct packed {
        logic      load_in;      // capture incoming item
        logic      norm_start;   // start the normalizer
        t_norm_src norm_src;
        logic      save_edge;    // keep result as the new-edge normal
        logic      save_old;     // keep result as the old-edge normal
        logic      save_avg;     // keep result as the averaged normal
        logic      emit_start;   // start the emit sequence
        logic      emit_which;   // 0: held point, 1: incoming point
        logic      emit_ok;      // apply offset (else pass through)
        logic      emit_avg;     // use averaged normal, else new-edge normal
        logic      emit_last;
        logic      shift_state;  // older <= newer, newer <= incoming
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic norm_busy;
        logic norm_zero;        // last normalized vector was zero
        logic emit_busy;
        logic in_last;
    } t_stat;

endpackage : pno_pkg
`default_nettype wire

FILE: rtl/polyline_normal_offset.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_normal_offset: sideways offset of a streamed polyline
// Each point moves along its left unit normal by the configured distance.
// Usage:
//   Points enter on the in channel (valid/ready), one struct per item, the
//   last point of a line marked by point_last. Offset points leave on the out
//   channel one point behind the input; a marked point also flushes itself.
//   The user must write offset_distance (signed Q16.16) on the cfg channel
//   only while idle; the block itself does not enforce this.
// Operation: one point at a time. Later points run one to three
//   normalizations on one shared unit (scale, square root, two divisions)
//   plus an emit per result. A point whose new segment has zero length
//   needs only one normalization; a first point needs none.
// Reset: synchronous active-low; clears the held points and sets the
//   distance to 0.
// Stall: the output register holds until taken; the next result waits for it
//   and the input stays not ready until the point's results are queued.
// ----------------------------------------------------------------------------
module polyline_normal_offset
    import pno_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire t_in_item               i_in_item,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output t_out_item                   o_out_item,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic signed [CoordW-1:0] i_cfg_data
);

    logic signed [CoordW-1:0] r_dist;
    t_cmd  cmd;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= '0;
        end else if (i_cfg_valid) begin
            r_dist <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    pno_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pno_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in_item),
        .i_dist      (r_dist),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule : polyline_normal_offset
`default_nettype wire

FILE: rtl/pno_norm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pno_norm: iterative unit-vector unit
// Scales the vector, takes a bit-serial square root, then two restoring
// divisions, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pno_norm
    import pno_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [33:0]      i_vx,
    input  wire logic signed [33:0]      i_vy,
    output logic                         o_busy,
    output logic                         o_zero,
    output logic signed [UnitW-1:0]      o_ux,
    output logic signed [UnitW-1:0]      o_uy
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCALE = 6'b000010,
        S_SQ    = 6'b000100,
        S_SQRT  = 6'b001000,
        S_DIVX  = 6'b010000,
        S_DIVY  = 6'b100000
    } t_nstate;

    t_nstate r_st, n_st;
    logic [33:0] r_ax, r_ay;
    logic        r_sx, r_sy;
    logic [63:0] r_n;       // radicand, later the division remainder
    logic [63:0] r_res;
    logic [5:0]  r_cnt;
    logic [31:0] r_len;
    logic [61:0] r_num;     // dividend shifted out one bit per cycle
    logic [31:0] r_q;
    logic        r_zero;
    logic signed [UnitW-1:0] r_ux, r_uy;

    logic [33:0] abs_x, abs_y;
    logic [61:0] x_sq, y_sq;
    logic [63:0] sq_sum;
    logic [63:0] sqrt_bit, sqrt_try, sqrt_next;
    logic [32:0] rem_sh;
    logic        rem_ge;

    assign abs_x = i_vx[33] ? 34'(-i_vx) : 34'(i_vx);
    assign abs_y = i_vy[33] ? 34'(-i_vy) : 34'(i_vy);
    // register after the squares: one multiplier each
    assign x_sq     = r_ax[30:0] * r_ax[30:0];
    assign y_sq     = r_ay[30:0] * r_ay[30:0];
    assign sq_sum   = 64'(x_sq) + 64'(y_sq);
    assign sqrt_bit = 64'd1 << {r_cnt[4:0], 1'b0};
    assign sqrt_try = r_res + sqrt_bit;
    assign sqrt_next = (r_n >= sqrt_try) ? (r_res >> 1) + sqrt_bit : r_res >> 1;
    assign rem_sh   = {r_n[31:0], r_num[61]};
    assign rem_ge   = rem_sh >= {1'b0, r_len};

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (i_start) n_st = S_SCALE;
            S_SCALE: if (r_zero) n_st = S_IDLE;
                     else if (r_ax[33:31] == '0 && r_ay[33:31] == '0 &&
                              (r_ax[30] || r_ay[30])) n_st = S_SQ;
            S_SQ:    n_st = S_SQRT;
            S_SQRT:  if (r_cnt == '0) n_st = S_DIVX;
            S_DIVX:  if (r_cnt == '0) n_st = S_DIVY;
            S_DIVY:  if (r_cnt == '0) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: if (i_start) begin
                r_ax   <= abs_x;
                r_ay   <= abs_y;
                r_sx   <= i_vx[33];
                r_sy   <= i_vy[33];
                r_zero <= (abs_x == '0) && (abs_y == '0);
            end
            S_SCALE: begin
                // bring the larger magnitude into [2^30, 2^31)
                if (r_ax[33:31] != '0 || r_ay[33:31] != '0) begin
                    r_ax <= r_ax >> 1;
                    r_ay <= r_ay >> 1;
                end else if (!(r_ax[30] || r_ay[30])) begin
                    r_ax <= r_ax << 1;
                    r_ay <= r_ay << 1;
                end
            end
            S_SQ: begin
                r_n   <= sq_sum;
                r_res <= '0;
                r_cnt <= 6'd31;
            end
            S_SQRT: begin
                if (r_cnt == '0) begin
                    r_len <= 32'(sqrt_next);
                    r_num <= 62'({r_ax[30:0], 30'd0}) + 62'(sqrt_next[32:1]);
                    r_n   <= '0;
                    r_cnt <= 6'd61;
                end else begin
                    if (r_n >= sqrt_try) begin
                        r_n <= r_n - sqrt_try;
                    end
                    r_res <= sqrt_next;
                    r_cnt <= r_cnt - 6'd1;
                end
            end
            S_DIVX, S_DIVY: begin
                r_q <= {r_q[30:0], rem_ge};
                if (r_cnt == '0) begin
                    if (r_st == S_DIVX) begin
                        r_ux  <= r_sx ? -$signed({r_q[30:0], rem_ge})
                                      : $signed({r_q[30:0], rem_ge});
                        r_num <= 62'({r_ay[30:0], 30'd0}) + 62'(r_len >> 1);
                        r_n   <= '0;
                        r_cnt <= 6'd61;
                    end else begin
                        r_uy <= r_sy ? -$signed({r_q[30:0], rem_ge})
                                     : $signed({r_q[30:0], rem_ge});
                    end
                end else begin
                    r_n   <= rem_ge ? 64'(rem_sh - {1'b0, r_len}) : 64'(rem_sh);
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt - 6'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_busy = (r_st != S_IDLE);
    assign o_zero = r_zero;
    assign o_ux   = r_ux;
    assign o_uy   = r_uy;

endmodule : pno_norm
`default_nettype wire

FILE: rtl/pno_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pno_datapath: point storage, normalizer and offset output stage
// Holds the older/held points, the edge normals and the output register.
// ----------------------------------------------------------------------------
module pno_datapath
    import pno_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    input  wire t_in_item                 i_item,
    input  wire logic signed [CoordW-1:0] i_dist,
    input  wire logic                     i_out_ready,
    output t_stat                         o_stat,
    output logic                          o_out_valid,
    output t_out_item                     o_out_item
);

    typedef enum logic [3:0] {
        E_IDLE = 4'b0001,
        E_MULX = 4'b0010,
        E_MULY = 4'b0100,
        E_WAIT = 4'b1000
    } t_estate;

    t_in_item r_in;
    logic signed [CoordW-1:0] r_ox, r_oy, r_nx, r_ny;
    logic signed [UnitW-1:0]  r_ex, r_ey, r_ax, r_ay, r_vx, r_vy;
    t_estate r_est;
    logic signed [CoordW-1:0] r_px, r_py;
    logic signed [CoordW-1:0] r_rx;
    logic signed [UnitW-1:0]  r_mx, r_my;
    logic r_ok, r_lastf;
    logic [62:0] r_prod;
    logic r_psign;
    logic r_out_valid;
    t_out_item r_out;

    logic signed [33:0] vx, vy;
    logic norm_busy, norm_zero;
    logic signed [UnitW-1:0] ux, uy;
    logic signed [CoordW-1:0] mul_n;
    logic [31:0] abs_d, abs_n;
    logic [63:0] prod;
    logic [32:0] q;
    logic signed [34:0] sum;
    logic signed [CoordW-1:0] sat;
    logic signed [CoordW-1:0] base;
    logic out_load;

    always_comb begin
        case (i_cmd.norm_src)
            SRC_EDGE_NEW: begin
                vx = 34'(r_in.point_x) - 34'(r_nx);
                vy = 34'(r_in.point_y) - 34'(r_ny);
            end
            SRC_EDGE_OLD: begin
                vx = 34'(r_nx) - 34'(r_ox);
                vy = 34'(r_ny) - 34'(r_oy);
            end
            default: begin
                vx = 34'(r_ax) + 34'(r_ex);
                vy = 34'(r_ay) + 34'(r_ey);
            end
        endcase
    end

    pno_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.norm_start),
        .i_vx    (vx),
        .i_vy    (vy),
        .o_busy  (norm_busy),
        .o_zero  (norm_zero),
        .o_ux    (ux),
        .o_uy    (uy)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) r_in <= i_item;
        // left normal is (-uy, ux)
        if (i_cmd.save_edge) begin r_ex <= -uy; r_ey <= ux; end
        if (i_cmd.save_old)  begin r_ax <= -uy; r_ay <= ux; end
        if (i_cmd.save_avg)  begin r_vx <= ux;  r_vy <= uy; end
        if (i_cmd.shift_state) begin
            r_ox <= r_nx;
            r_oy <= r_ny;
            r_nx <= r_in.point_x;
            r_ny <= r_in.point_y;
        end
    end

    // emit: one multiply per cycle, registered, then round and saturate
    assign mul_n = (r_est == E_MULX) ? r_mx : r_my;
    assign abs_d = i_dist[31] ? 32'(-i_dist) : 32'(i_dist);
    assign abs_n = mul_n[31] ? 32'(-mul_n) : 32'(mul_n);
    assign prod  = abs_d * abs_n;
    assign q     = 33'((64'(r_prod) + 64'(1 << 29)) >> 30);
    assign base  = (r_est == E_MULY) ? r_px : r_py;
    assign sum   = 35'(base) + (r_psign ? -35'(q) : 35'(q));
    assign sat   = (sum > 35'sd2147483647) ? 32'sh7fffffff :
                   (sum < -35'sd2147483648) ? 32'sh80000000 : 32'(sum);
    // move the finished item into the output register once it is free
    assign out_load = (r_est == E_WAIT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est       <= E_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            case (r_est)
                E_IDLE: if (i_cmd.emit_start) begin
                    r_px  <= i_cmd.emit_which ? r_in.point_x : r_nx;
                    r_py  <= i_cmd.emit_which ? r_in.point_y : r_ny;
                    r_mx  <= i_cmd.emit_avg ? r_vx : r_ex;
                    r_my  <= i_cmd.emit_avg ? r_vy : r_ey;
                    r_ok  <= i_cmd.emit_ok && (i_dist != '0);
                    r_lastf <= i_cmd.emit_last;
                    r_est <= E_MULX;
                end
                E_MULX: r_est <= E_MULY;
                E_MULY: r_est <= E_WAIT;
                E_WAIT: if (out_load) r_est <= E_IDLE;
                default: r_est <= E_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_est == E_MULX || r_est == E_MULY) begin
            r_prod  <= prod[62:0];
            r_psign <= i_dist[31] ^ mul_n[31];
        end
        // hold x aside so a waiting output item stays intact
        if (r_est == E_MULY) r_rx <= r_ok ? sat : r_px;
        if (out_load) begin
            r_out.out_x    <= r_rx;
            r_out.out_y    <= r_ok ? sat : r_py;
            r_out.out_last <= r_lastf;
        end
    end

    assign o_stat.norm_busy = norm_busy;
    assign o_stat.norm_zero = norm_zero;
    assign o_stat.emit_busy = (r_est != E_IDLE);
    assign o_stat.in_last   = r_in.point_last;
    assign o_out_valid      = r_out_valid;
    assign o_out_item       = r_out;

endmodule : pno_datapath
`default_nettype wire

FILE: rtl/pno_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pno_ctrl: sequencer for the polyline normal offset
// Steps one point through normalize and emit commands.
// ----------------------------------------------------------------------------
module pno_ctrl
    import pno_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [9:0] {
        C_IDLE   = 10'b0000000001,
        C_DECIDE = 10'b0000000010,
        C_EWAIT  = 10'b0000000100,
        C_OWAIT  = 10'b0000001000,
        C_SWAIT  = 10'b0000010000,
        C_EMIT1  = 10'b0000100000,
        C_E1WAIT = 10'b0001000000,
        C_EMIT2  = 10'b0010000000,
        C_E2WAIT = 10'b0100000000,
        C_FINISH = 10'b1000000000
    } t_cstate;

    t_cstate r_st, n_st;
    logic [1:0] r_held, n_held;
    logic r_eok, n_eok, r_ok, n_ok;

    always_comb begin
        n_st   = r_st;
        n_held = r_held;
        n_eok  = r_eok;
        n_ok   = r_ok;
        o_cmd  = '0;
        o_cmd.norm_src = SRC_EDGE_NEW;
        o_in_ready = 1'b0;
        case (r_st)
            C_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_st = C_DECIDE;
                end
            end
            C_DECIDE: begin
                if (r_held == 2'd0) begin
                    if (i_stat.in_last) begin
                        n_eok = 1'b0;
                        n_st  = C_EMIT2;
                    end else begin
                        o_cmd.shift_state = 1'b1;
                        n_held = 2'd1;
                        n_st   = C_IDLE;
                    end
                end else begin
                    o_cmd.norm_start = 1'b1;
                    o_cmd.norm_src   = SRC_EDGE_NEW;
                    n_st = C_EWAIT;
                end
            end
            C_EWAIT: begin
                o_cmd.norm_src = SRC_EDGE_NEW;
                if (!i_stat.norm_busy) begin
                    o_cmd.save_edge = 1'b1;
                    n_eok = !i_stat.norm_zero;
                    n_ok  = !i_stat.norm_zero;
                    if (r_held == 2'd2 && !i_stat.norm_zero) begin
                        o_cmd.norm_start = 1'b1;
                        o_cmd.norm_src   = SRC_EDGE_OLD;
                        n_st = C_OWAIT;
                    end else begin
                        n_st = C_EMIT1;
                    end
                end
            end
            C_OWAIT: begin
                o_cmd.norm_src = SRC_EDGE_OLD;
                if (!i_stat.norm_busy) begin
                    o_cmd.save_old = 1'b1;
                    n_ok = !i_stat.norm_zero;
                    n_st = C_SWAIT;
                end
            end
            C_SWAIT: begin
                // launch the sum normalize once, then wait on it
                o_cmd.norm_src = SRC_SUM;
                if (!r_ok) begin
                    n_st = C_EMIT1;
                end else if (!i_stat.norm_busy && n_held != 2'd3) begin
                    o_cmd.norm_start = 1'b1;
                    n_held = 2'd3;
                end else if (!i_stat.norm_busy) begin
                    o_cmd.save_avg = 1'b1;
                    n_ok   = !i_stat.norm_zero;
                    n_held = 2'd2;
                    n_st   = C_EMIT1;
                end
            end
            C_EMIT1: begin
                o_cmd.emit_start = 1'b1;
                o_cmd.emit_which = 1'b0;
                o_cmd.emit_ok    = (r_held == 2'd1) ? r_eok : r_ok;
                o_cmd.emit_avg   = (r_held != 2'd1);
                n_st = C_E1WAIT;
            end
            C_E1WAIT: begin
                if (!i_stat.emit_busy) n_st = i_stat.in_last ? C_EMIT2 : C_FINISH;
            end
            C_EMIT2: begin
                o_cmd.emit_start = 1'b1;
                o_cmd.emit_which = 1'b1;
                o_cmd.emit_ok    = r_eok && (r_held != 2'd0);
                o_cmd.emit_last  = 1'b1;
                n_st = C_E2WAIT;
            end
            C_E2WAIT: begin
                if (!i_stat.emit_busy) begin
                    n_held = 2'd0;
                    n_st   = C_IDLE;
                end
            end
            C_FINISH: begin
                o_cmd.shift_state = 1'b1;
                n_held = 2'd2;
                n_st   = C_IDLE;
            end
            default: n_st = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= C_IDLE;
            r_held <= 2'd0;
            r_eok  <= 1'b0;
            r_ok   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_held <= n_held;
            r_eok  <= n_eok;
            r_ok   <= n_ok;
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_st == C_IDLE)) else $error("ready outside idle");
    a_held_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == C_IDLE) |-> (r_held != 2'd3)) else $error("bad held count");
    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_start |=> !o_cmd.emit_start) else $error("double emit");

endmodule : pno_ctrl
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for polyline_normal_offset
// Streams polylines through the block under several offset distances and idle
// patterns, predicts each offset point in Q16.16 / Q1.30 fixed point and
// compares every output item with all its fields, in order.
// ----------------------------------------------------------------------------
module tb;
    import pno_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic signed [31:0] cfg_data = '0;

    polyline_normal_offset dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    // predictor state
    longint dist_q, older_x, older_y, newer_x, newer_y;
    int     held;

    t_in_item  pending_points[$];
    t_out_item expected_points[$];
    int  mismatches = 0;
    int  points_checked = 0;
    longint cycles = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_go = 0;
    bit  hold_on = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd8000000) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // long receiver hold-off, counted here in cycles
    initial begin
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_on <= 1'b0;
    end

    function automatic longint isqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic bit unit_of(longint vx, longint vy, output longint ux,
                                   output longint uy);
        longint unsigned ax, ay, m, len, qx, qy;
        ax = vx < 0 ? -vx : vx;
        ay = vy < 0 ? -vy : vy;
        ux = 0;
        uy = 0;
        if (ax == 0 && ay == 0) return 0;
        m = ax > ay ? ax : ay;
        while (m >= (64'd1 << 31)) begin
            ax >>= 1; ay >>= 1; m >>= 1;
        end
        while (m < (64'd1 << 30)) begin
            ax <<= 1; ay <<= 1; m <<= 1;
        end
        len = isqrt(ax * ax + ay * ay);
        qx = ((ax << 30) + len / 2) / len;
        qy = ((ay << 30) + len / 2) / len;
        ux = vx < 0 ? -longint'(qx) : longint'(qx);
        uy = vy < 0 ? -longint'(qy) : longint'(qy);
        return 1;
    endfunction

    function automatic bit left_normal(longint ax, longint ay, longint bx, longint by,
                                       output longint nx, output longint ny);
        longint ux, uy;
        bit ok;
        ok = unit_of(bx - ax, by - ay, ux, uy);
        nx = -uy;
        ny = ux;
        return ok;
    endfunction

    function automatic longint shift_of(longint d, longint n);
        longint unsigned ad, an, q;
        ad = d < 0 ? -d : d;
        an = n < 0 ? -n : n;
        q = (ad * an + (64'd1 << 29)) >> 30;
        return ((d < 0) != (n < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void push_offset(longint x, longint y, bit ok, longint nx,
                                        longint ny, bit last);
        t_out_item r;
        if (ok && dist_q != 0) begin
            x = sat32(x + shift_of(dist_q, nx));
            y = sat32(y + shift_of(dist_q, ny));
        end
        r.out_x = x[31:0];
        r.out_y = y[31:0];
        r.out_last = last;
        expected_points.insert(expected_points.size(), r);
    endfunction

    function automatic void predict_point(t_in_item p);
        longint px, py, ex, ey, ax, ay, nx, ny;
        bit eok, ok;
        px = longint'($signed(p.point_x));
        py = longint'($signed(p.point_y));
        nx = 0; ny = 0; ax = 0; ay = 0;
        if (held == 0) begin
            if (p.point_last) begin
                push_offset(px, py, 0, 0, 0, 1);
            end else begin
                newer_x = px; newer_y = py; held = 1;
            end
            return;
        end
        eok = left_normal(newer_x, newer_y, px, py, ex, ey);
        if (held == 1) begin
            push_offset(newer_x, newer_y, eok, ex, ey, 0);
        end else begin
            ok = eok && left_normal(older_x, older_y, newer_x, newer_y, ax, ay);
            if (ok) ok = unit_of(ax + ex, ay + ey, nx, ny);
            push_offset(newer_x, newer_y, ok, nx, ny, 0);
        end
        if (p.point_last) begin
            push_offset(px, py, eok, ex, ey, 1);
            older_x = 0; older_y = 0; newer_x = 0; newer_y = 0; held = 0;
        end else begin
            older_x = newer_x; older_y = newer_y;
            newer_x = px; newer_y = py; held = 2;
        end
    endfunction

    // sender: hold the item until accepted, then maybe idle
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                predict_point(in_item);
            end
            if (!in_valid || in_ready) begin
                if (pending_points.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_item <= pending_points.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each taken item against the oldest prediction
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                points_checked <= points_checked + 1;
                if (expected_points.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected item x=%h y=%h last=%b",
                                 out_item.out_x, out_item.out_y, out_item.out_last);
                end else begin
                    t_out_item e;
                    e = expected_points.pop_front();
                    if (e !== out_item) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch exp x=%h y=%h last=%b got x=%h y=%h last=%b",
                                     e.out_x, e.out_y, e.out_last, out_item.out_x,
                                     out_item.out_y, out_item.out_last);
                    end
                end
            end
            if (hold_on) begin
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic t_in_item mk(longint x, longint y, bit last);
        t_in_item p;
        p.point_x = x[31:0];
        p.point_y = y[31:0];
        p.point_last = last;
        return p;
    endfunction

    function automatic void queue_point(longint x, longint y, bit last);
        pending_points.insert(pending_points.size(), mk(x, y, last));
    endfunction

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'(int'($urandom_range(2000)) - 1000) <<< 16;
            default: return 32'(int'($urandom_range(40)) - 20);
        endcase
    endfunction

    // random polylines of 1..6 points, mostly well formed
    task automatic queue_lines(int n_points);
        int len, mode, k;
        longint x, y;
        while (n_points > 0) begin
            len = $urandom_range(6, 1);
            mode = $urandom_range(2);
            x = longint'($signed(rand_coord(mode)));
            y = longint'($signed(rand_coord(mode)));
            for (k = 0; k < len; k++) begin
                if ($urandom_range(9) == 0) begin
                    // repeat the point: zero-length segment
                end else if (mode == 0) begin
                    x = longint'($signed(rand_coord(0)));
                    y = longint'($signed(rand_coord(0)));
                end else begin
                    x = longint'($signed(32'(x + longint'($signed(rand_coord(mode))))));
                    y = longint'($signed(32'(y + longint'($signed(rand_coord(mode))))));
                end
                queue_point(x, y, k == len - 1);
            end
            n_points -= len;
        end
    endtask

    task automatic wait_drained();
        while (pending_points.size() > 0 || in_valid || expected_points.size() > 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic write_distance(logic signed [31:0] d);
        cfg_valid <= 1'b1;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        dist_q = longint'(d);
    endtask

    localparam logic signed [31:0] MaxC = 32'sh7fffffff;
    localparam logic signed [31:0] MinC = 32'sh80000000;

    logic signed [31:0] distances[6] = '{32'sh0002_0000, 32'sh7fffffff, 32'sh80000000,
                                         32'sh0, -32'sh0001_8000, 32'sh1};
    int idle_phase[4][2] = '{'{0, 0}, '{66, 0}, '{0, 66}, '{30, 30}};

    initial begin
        dist_q = 0; held = 0;
        older_x = 0; older_y = 0; newer_x = 0; newer_y = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_distance(distances[0]);
        // directed: one-point line, straight, turn, U-turn, repeats, extremes
        queue_point(5, 7, 1);
        queue_point(0, 0, 0);
        queue_point(65536, 0, 0);
        queue_point(65536, 65536, 0);
        queue_point(65536, 0, 0);
        queue_point(65536, 0, 0);
        queue_point(0, 0, 1);
        queue_point(MinC, MinC, 0);
        queue_point(MaxC, MaxC, 0);
        queue_point(MinC, MaxC, 1);
        queue_point(MaxC, MinC, 0);
        queue_point(MaxC, MinC, 1);
        queue_point(-1, -1, 0);
        queue_point(1, 1, 0);
        queue_point(-1, -1, 1);
        wait_drained();
        write_distance(MaxC);
        queue_point(MaxC, 0, 0);
        queue_point(MaxC, 100, 0);
        queue_point(0, MinC, 1);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            write_distance(distances[ph]);
            send_idle_pct = idle_phase[ph % 4][0];
            recv_stall_pct = idle_phase[ph % 4][1];
            queue_lines(150);
            if (ph == 1) begin
                hold_go = 1;
            end
            wait_drained();
            write_distance($urandom);
            queue_lines(150);
            wait_drained();
        end
        $display("covered %0d output items over 12 random phases plus directed lines",
                 points_checked);
        $display("distances included zero and both extremes; mismatches %0d", mismatches);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
